### design/fpfc_pkg.sv
package fpfc_pkg;

   typedef enum logic [1:0] {
      MODE_INT_TO_FIX   = 2'd0,
      MODE_FLT_TO_FIX   = 2'd1,
      MODE_FIX_TO_FLT   = 2'd2,
      MODE_FIX_TO_INT   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] int_in;
      logic [31:0]        float_in;
      logic signed [31:0] raw_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] raw_out;
      logic [31:0]        float_out;
      logic signed [23:0] int_out;
      logic               overflow;
   } rsp_type;

endpackage

### design/fixed_point_format_converter_unit.sv
// Fixed-point format converter, Q(32-FRAC_BITS).FRAC_BITS.
// Input channel req_*: req_valid/req_stall/req_data; a transfer happens
// when valid is high and stall is low. req_data.mode picks the conversion:
// int to fixed, float to fixed, fixed to float, fixed to int.
// Output channel rsp_*: one result per input item, same order.
// An input transfer is written to the input register; single-pass
// conversion logic then feeds the result register that drives rsp_valid.
// Throughput: one item per cycle while rsp_stall is low (two-stage pipe).
// A stage advances when the stage after it is empty or moving, so a stall
// on rsp_stall backs up into req_stall only when both stages are full.
// Reset clears both valid flags; payload registers are not reset.
module fixed_point_format_converter_unit import fpfc_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff;
   rsp_type conv;
   logic    out_move, in_move;

   fpfc_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .req(in_ff),
      .rsp(conv)
   );

   assign out_move   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign in_move    = !in_vld_ff || out_move;
   assign req_stall  = !in_move;
   assign in_vld_in  = in_move ? req_valid : in_vld_ff;
   assign out_vld_in = out_move ? 1'b1 : (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (in_move && req_valid) in_ff <= req_data;
      if (out_move) out_ff <= conv;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

### design/fpfc_core.sv
module fpfc_core import fpfc_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  req_type req,
   output rsp_type rsp
);

   localparam int FB = FRAC_BITS;

   // mode 0
   logic signed [63:0] i2f_wide;
   logic               i2f_ovf;
   logic [31:0]        i2f_val;

   // mode 1
   logic        f_neg;
   logic [7:0]  f_ex;
   logic [23:0] f_man;
   logic signed [9:0] f_sh;
   logic [5:0]  f_n;
   logic [63:0] f_mag;
   logic [63:0] f_rnd;
   logic        f2x_ovf;
   logic [31:0] f2x_val;

   // mode 2
   logic        x_neg;
   logic [31:0] x_mag;
   logic [4:0]  x_p;
   logic [4:0]  x_r;
   logic [31:0] x_rem;
   logic [31:0] x_half;
   logic [24:0] x_keep;
   logic [5:0]  x_pf;
   logic [7:0]  x_e;
   logic [31:0] x2f_val;

   // mode 3
   logic signed [31:0] x_q;
   logic        x2i_ovf;
   logic [23:0] x2i_val;

   always_comb begin
      i2f_wide = 64'(signed'(req.int_in)) <<< FB;
      i2f_ovf  = 1'b0;
      i2f_val  = i2f_wide[31:0];
      if (i2f_wide > 64'sh7FFFFFFF) begin
         i2f_ovf = 1'b1;
         i2f_val = 32'h7FFFFFFF;
      end else if (i2f_wide < -64'sh80000000) begin
         i2f_ovf = 1'b1;
         i2f_val = 32'h80000000;
      end
   end

   always_comb begin
      f_neg   = req.float_in[31];
      f_ex    = req.float_in[30:23];
      f_man   = {1'b0, req.float_in[22:0]};
      f2x_ovf = 1'b0;
      f2x_val = 32'd0;
      f_mag   = 64'd0;
      f_rnd   = 64'd0;
      f_n     = 6'd0;
      if (f_ex == 8'd0) begin
         f_sh = 10'(FB) - 10'sd149;
      end else begin
         f_man[23] = 1'b1;
         f_sh = signed'({2'b00, f_ex}) - 10'sd150 + 10'(FB);
      end
      if (f_ex == 8'hFF) begin
         f2x_ovf = 1'b1;
         if (req.float_in[22:0] != 23'd0) f2x_val = 32'd0;
         else f2x_val = f_neg ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (f_man != 24'd0) begin
         if (f_sh >= 0) begin
            if (f_sh > 10'sd38) f_mag = 64'h1_0000_0000;
            else f_mag = 64'(f_man) << f_sh[5:0];
         end else begin
            if (f_sh <= -10'sd25) begin
               f_mag = 64'd0;
            end else begin
               f_n   = 6'(-f_sh);
               f_rnd = 64'(f_man) + (64'd1 << (f_n - 6'd1));
               f_mag = f_rnd >> f_n;
            end
         end
         if (f_neg) begin
            if (f_mag > 64'h8000_0000) begin
               f2x_ovf = 1'b1;
               f_mag = 64'h8000_0000;
            end
            f2x_val = 32'(64'd0 - f_mag);
         end else begin
            if (f_mag > 64'h7FFF_FFFF) begin
               f2x_ovf = 1'b1;
               f_mag = 64'h7FFF_FFFF;
            end
            f2x_val = f_mag[31:0];
         end
      end
   end

   always_comb begin
      x_neg  = req.raw_in[31];
      x_mag  = x_neg ? 32'(-req.raw_in) : 32'(req.raw_in);
      x_p    = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x_mag[i]) x_p = 5'(i);
      end
      x_r    = 5'd0;
      x_rem  = 32'd0;
      x_half = 32'd0;
      x_pf   = {1'b0, x_p};
      if (x_p > 5'd23) begin
         x_r    = x_p - 5'd23;
         x_rem  = x_mag & ((32'd1 << x_r) - 32'd1);
         x_half = 32'd1 << (x_r - 5'd1);
         x_keep = 25'(x_mag >> x_r);
         if (x_rem > x_half || (x_rem == x_half && x_keep[0]))
            x_keep = x_keep + 25'd1;
         if (x_keep[24]) begin
            x_keep = x_keep >> 1;
            x_pf   = x_pf + 6'd1;
         end
      end else begin
         x_keep = 25'(x_mag << (5'd23 - x_p));
      end
      x_e = 8'(x_pf) - 8'(FB) + 8'd127;
      if (req.raw_in == 32'sd0) x2f_val = 32'd0;
      else x2f_val = {x_neg, x_e, x_keep[22:0]};
   end

   always_comb begin
      x_q     = req.raw_in >>> FB;
      x2i_ovf = 1'b0;
      x2i_val = x_q[23:0];
      if (x_q > 32'sd8388607) begin
         x2i_ovf = 1'b1;
         x2i_val = 24'h7FFFFF;
      end else if (x_q < -32'sd8388608) begin
         x2i_ovf = 1'b1;
         x2i_val = 24'h800000;
      end
   end

   always_comb begin
      rsp = '0;
      unique case (mode_type'(req.mode))
         MODE_INT_TO_FIX: begin
            rsp.raw_out  = i2f_val;
            rsp.overflow = i2f_ovf;
         end
         MODE_FLT_TO_FIX: begin
            rsp.raw_out  = f2x_val;
            rsp.overflow = f2x_ovf;
         end
         MODE_FIX_TO_FLT: begin
            rsp.float_out = x2f_val;
         end
         MODE_FIX_TO_INT: begin
            rsp.int_out  = x2i_val;
            rsp.overflow = x2i_ovf;
         end
         default: rsp = '0;
      endcase
   end

endmodule

### design/fpfc_checker.sv
module fpfc_checker import fpfc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty output");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall |=> ##1 rsp_valid)
      else $error("result missing after two cycles");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind fixed_point_format_converter_unit fpfc_checker u_fpfc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

### tb/tb_fixed_point_format_converter_unit.sv
module tb_fixed_point_format_converter_unit;
   import fpfc_pkg::*;

   localparam int FRAC_BITS = 8;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      error_count;
   bit      rsp_stall_en;
   int      rsp_wait;

   fixed_point_format_converter_unit #(.FRAC_BITS(FRAC_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [31:0] saturate_raw(longint v, ref logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] float_to_raw(logic [31:0] bits, ref logic ovf);
      logic           neg;
      int             ex;
      int             sh;
      int             n;
      logic [63:0]    man;
      logic [63:0]    mag;
      neg = bits[31];
      ex  = bits[30:23];
      man = {41'd0, bits[22:0]};
      if (ex == 255) begin
         ovf = 1'b1;
         if (man != 0) return 32'd0;
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (ex == 0) sh = -149 + FRAC_BITS;
      else begin
         man[23] = 1'b1;
         sh = ex - 150 + FRAC_BITS;
      end
      if (man == 0) return 32'd0;
      if (sh >= 0) begin
         if (sh > 38) begin
            ovf = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         mag = man << sh;
      end else begin
         n = -sh;
         if (n >= 25) mag = 0;
         else mag = (man + (64'd1 << (n - 1))) >> n;
      end
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            mag = 64'h8000_0000;
         end
         return -mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         mag = 64'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic logic [31:0] raw_to_float(logic signed [31:0] raw);
      logic [63:0] mag;
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      logic        sign;
      logic [7:0]  e;
      int          p;
      int          r;
      if (raw == 0) return 32'd0;
      sign = raw[31];
      mag  = sign ? -longint'(raw) : longint'(raw);
      p = 0;
      while (p < 40 && (mag >> (p + 1)) != 0) p++;
      if (p > 23) begin
         r    = p - 23;
         rem  = mag & ((64'd1 << r) - 1);
         half = 64'd1 << (r - 1);
         keep = mag >> r;
         if (rem > half || (rem == half && keep[0])) keep++;
         if (keep >> 24) begin
            keep = keep >> 1;
            p++;
         end
      end else keep = mag << (23 - p);
      e = 8'(p - FRAC_BITS + 127);
      return {sign, e, keep[22:0]};
   endfunction

   function automatic logic [23:0] raw_to_int(logic signed [31:0] raw, ref logic ovf);
      longint q;
      q = longint'(raw) >>> FRAC_BITS;
      if (q > 8388607) begin
         ovf = 1'b1;
         q = 8388607;
      end
      if (q < -8388608) begin
         ovf = 1'b1;
         q = -8388608;
      end
      return q[23:0];
   endfunction

   function automatic rsp_type convert(req_type req);
      rsp_type r;
      logic    ovf;
      r   = '0;
      ovf = 1'b0;
      case (mode_type'(req.mode))
         MODE_INT_TO_FIX:
            r.raw_out = saturate_raw(longint'(req.int_in) * (64'sd1 << FRAC_BITS), ovf);
         MODE_FLT_TO_FIX: r.raw_out = float_to_raw(req.float_in, ovf);
         MODE_FIX_TO_FLT: r.float_out = raw_to_float(req.raw_in);
         MODE_FIX_TO_INT: r.int_out = raw_to_int(req.raw_in, ovf);
      endcase
      r.overflow = ovf;
      return r;
   endfunction

   always @(posedge clock) begin
      int wait_draw;
      if (reset) begin
         rsp_stall <= 1'b1;
         rsp_wait  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            wait_draw = rsp_stall_en ? $urandom_range(0, 10) : 0;
            rsp_wait  <= wait_draw;
            rsp_stall <= (wait_draw != 0);
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               error_count++;
            end else begin
               rsp_type exp_r;
               exp_r = expected_q.pop_front();
               if (rsp_data.raw_out !== exp_r.raw_out)
                  $display("%0t: raw_out expected %h actual %h", $time, exp_r.raw_out,
                           rsp_data.raw_out);
               if (rsp_data.float_out !== exp_r.float_out)
                  $display("%0t: float_out expected %h actual %h", $time, exp_r.float_out,
                           rsp_data.float_out);
               if (rsp_data.int_out !== exp_r.int_out)
                  $display("%0t: int_out expected %h actual %h", $time, exp_r.int_out,
                           rsp_data.int_out);
               if (rsp_data.overflow !== exp_r.overflow)
                  $display("%0t: overflow expected %b actual %b", $time, exp_r.overflow,
                           rsp_data.overflow);
               if (rsp_data !== exp_r) error_count++;
            end
         end else if (rsp_wait > 1) begin
            rsp_wait  <= rsp_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_wait  <= 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   bit gaps_en;

   task automatic send_item(logic [1:0] mode, logic [31:0] operand);
      req_type req;
      int      gap;
      req.mode     = mode;
      req.int_in   = $urandom;
      req.float_in = $urandom;
      req.raw_in   = $urandom;
      case (mode_type'(mode))
         MODE_INT_TO_FIX: req.int_in   = operand;
         MODE_FLT_TO_FIX: req.float_in = operand;
         default:         req.raw_in   = operand;
      endcase
      gap = gaps_en ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(convert(req));
   endtask

   task automatic test_int_to_fixed();
      send_item(MODE_INT_TO_FIX, 32'd0);
      send_item(MODE_INT_TO_FIX, 32'd1);
      send_item(MODE_INT_TO_FIX, 32'hFFFF_FFFF);
      send_item(MODE_INT_TO_FIX, 32'h007F_FFFF);
      send_item(MODE_INT_TO_FIX, 32'hFF80_0000);
      send_item(MODE_INT_TO_FIX, 32'h0080_0000);
      send_item(MODE_INT_TO_FIX, 32'h7FFF_FFFF);
      send_item(MODE_INT_TO_FIX, 32'h8000_0000);
   endtask

   task automatic test_float_to_fixed();
      send_item(MODE_FLT_TO_FIX, 32'h3F80_0000);
      send_item(MODE_FLT_TO_FIX, 32'h7F80_0000);
      send_item(MODE_FLT_TO_FIX, 32'hFF80_0000);
      send_item(MODE_FLT_TO_FIX, 32'h7FC0_0001);
      send_item(MODE_FLT_TO_FIX, 32'h8000_0000);
      send_item(MODE_FLT_TO_FIX, 32'h0000_0001);
      send_item(MODE_FLT_TO_FIX, 32'h3B00_0000);
      send_item(MODE_FLT_TO_FIX, 32'hBB00_0000);
      send_item(MODE_FLT_TO_FIX, 32'h4B00_0000);
      send_item(MODE_FLT_TO_FIX, 32'hCB00_0000);
      send_item(MODE_FLT_TO_FIX, 32'h4AFF_FFFF);
   endtask

   task automatic test_fixed_to_other();
      send_item(MODE_FIX_TO_FLT, 32'd0);
      send_item(MODE_FIX_TO_FLT, 32'h7FFF_FFFF);
      send_item(MODE_FIX_TO_FLT, 32'h8000_0000);
      send_item(MODE_FIX_TO_FLT, 32'h0100_0001);
      send_item(MODE_FIX_TO_INT, 32'hFFFF_FFFF);
      send_item(MODE_FIX_TO_INT, 32'h7FFF_FFFF);
      send_item(MODE_FIX_TO_INT, 32'h8000_0000);
   endtask

   task automatic test_random(int count);
      logic [31:0] v;
      logic [1:0]  mode;
      for (int i = 0; i < count; i++) begin
         mode = 2'($urandom_range(0, 3));
         v = $urandom;
         case ($urandom_range(0, 5))
            0: v = $signed(v) >>> $urandom_range(0, 31);
            1: if (mode == MODE_FLT_TO_FIX)
                  v[30:23] = 8'($urandom_range(100, 165));
            2: if (mode == MODE_FLT_TO_FIX) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: ;
         endcase
         if (i % 400 == 0) gaps_en = !gaps_en;
         if (i % 400 == 200) rsp_stall_en = !rsp_stall_en;
         send_item(mode, v);
      end
   endtask

   initial begin
      int wait_cycles;
      error_count  = 0;
      gaps_en      = 1'b1;
      rsp_stall_en = 1'b1;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_int_to_fixed();
      test_float_to_fixed();
      test_fixed_to_other();
      test_random(1950);
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (expected_q.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### fixed_point_format_converter_unit.f
design/fpfc_pkg.sv
design/fpfc_core.sv
design/fixed_point_format_converter_unit.sv
design/fpfc_checker.sv
tb/tb_fixed_point_format_converter_unit.sv
